// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the clip block; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LSRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LSRC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define LSRC_ASSERT(lbl, clk, rst_n, prop, msg)

`define LSRC_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== src/lsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrc_pkg
// Types, constants and helpers for the segment/rectangle clipper.
// ----------------------------------------------------------------------------
package lsrc_pkg;

    localparam int CW = 16;          // coordinate width, Q12.4
    localparam int DW = CW + 1;      // coordinate difference width
    localparam int PW = 2 * DW;      // product width
    localparam int CR = CW + 2;      // crossing width before range check
    localparam int QUEUE_DEPTH_DEF = 2;

    // lane order is the edge priority
    localparam int LANE_LEFT   = 0;
    localparam int LANE_RIGHT  = 1;
    localparam int LANE_TOP    = 2;
    localparam int LANE_BOTTOM = 3;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_TOP    = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    localparam logic signed [CW-1:0] RST_LEFT   = CW'(0);
    localparam logic signed [CW-1:0] RST_RIGHT  = CW'(10240);
    localparam logic signed [CW-1:0] RST_TOP    = CW'(0);
    localparam logic signed [CW-1:0] RST_BOTTOM = CW'(7680);

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } in_t;

    typedef struct packed {
        logic                 visible;
        logic signed [CW-1:0] left_x;
        logic signed [CW-1:0] left_y;
        logic signed [CW-1:0] right_x;
        logic signed [CW-1:0] right_y;
    } out_t;

    typedef struct packed {
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] right;
        logic signed [CW-1:0] top;
        logic signed [CW-1:0] bottom;
    } win_t;

    // classified segment, before multiply
    typedef struct packed {
        logic                 visible;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic [3:0]           hit;
        logic [3:0]           neg;
        logic                 y1_lt;
        logic                 y1_gt;
        logic [DW-1:0]        mdx;
        logic [DW-1:0]        mdy;
        logic [3:0][DW-1:0]   mt;
    } cls_t;

    // queue entry
    typedef struct packed {
        logic                 visible;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic [3:0]           hit;
        logic [3:0]           neg;
        logic                 y1_lt;
        logic                 y1_gt;
        logic [DW-1:0]        mdx;
        logic [DW-1:0]        mdy;
        logic [3:0][PW-1:0]   prod;
    } job_t;

    // divider pipeline stage
    typedef struct packed {
        logic                 visible;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic [3:0]           hit;
        logic [3:0]           neg;
        logic                 y1_lt;
        logic                 y1_gt;
        logic [DW-1:0]        mdx;
        logic [DW-1:0]        mdy;
        logic [3:0][DW-1:0]   rem;
        logic [3:0][DW-1:0]   low;
        logic [3:0][DW-1:0]   quo;
    } stg_t;

    function automatic logic [DW-1:0] mag(logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [DW:0] div_step(logic [DW-1:0] rem, logic bit_in,
                                             logic [DW-1:0] dvs);
        logic [DW:0] r2;
        logic [DW:0] d2;
        r2 = {rem, bit_in};
        d2 = {1'b0, dvs};
        if (r2 >= d2)
            return {1'b1, DW'(r2 - d2)};
        else
            return {1'b0, r2[DW-1:0]};
    endfunction

endpackage

// ===== src/lsrc_front.sv =====
// ----------------------------------------------------------------------------
// lsrc_front
// Orders endpoints, classifies the segment and forms the crossing products.
// ----------------------------------------------------------------------------
module lsrc_front
    import lsrc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  win_t  win,
    input  logic  in_valid,
    output logic  in_ready,
    input  in_t   in_data,
    output logic  push,
    output job_t  job,
    input  logic  q_full
);

    cls_t cls_next;
    cls_t cls_reg;
    logic cls_valid_reg;
    logic cls_valid_next;
    logic load;

    always_comb
    begin
        logic signed [CW-1:0] x1, y1, x2, y2, ylo, yhi;
        logic signed [DW-1:0] dx, dy, tl, tr, tt, tb;
        logic in1, in2;
        if (in_data.start_x > in_data.end_x)
        begin
            x1 = in_data.end_x;   y1 = in_data.end_y;
            x2 = in_data.start_x; y2 = in_data.start_y;
        end
        else
        begin
            x1 = in_data.start_x; y1 = in_data.start_y;
            x2 = in_data.end_x;   y2 = in_data.end_y;
        end
        ylo = (y1 < y2) ? y1 : y2;
        yhi = (y1 < y2) ? y2 : y1;
        in1 = x1 >= win.left && x1 < win.right && y1 >= win.top && y1 < win.bottom;
        in2 = x2 >= win.left && x2 < win.right && y2 >= win.top && y2 < win.bottom;
        dx = DW'(x2) - DW'(x1);
        dy = DW'(y2) - DW'(y1);
        tl = DW'(win.left) - DW'(x1);
        tr = DW'(win.right) - DW'(x1);
        tt = DW'(win.top) - DW'(y1);
        tb = DW'(win.bottom) - DW'(y1);

        cls_next.visible = (in1 || in2) && !(x1 == x2 && y1 == y2);
        cls_next.x1 = x1;
        cls_next.y1 = y1;
        cls_next.x2 = x2;
        cls_next.y2 = y2;
        cls_next.hit[LANE_LEFT]   = x1 < win.left && win.left < x2;
        cls_next.hit[LANE_RIGHT]  = x1 < win.right && win.right < x2;
        cls_next.hit[LANE_TOP]    = ylo < win.top && win.top < yhi;
        cls_next.hit[LANE_BOTTOM] = ylo < win.bottom && win.bottom < yhi;
        // dx is never negative after ordering
        cls_next.neg[LANE_LEFT]   = dy[DW-1] ^ tl[DW-1];
        cls_next.neg[LANE_RIGHT]  = dy[DW-1] ^ tr[DW-1];
        cls_next.neg[LANE_TOP]    = tt[DW-1] ^ dy[DW-1];
        cls_next.neg[LANE_BOTTOM] = tb[DW-1] ^ dy[DW-1];
        cls_next.y1_lt = y1 < y2;
        cls_next.y1_gt = y1 > y2;
        cls_next.mdx = mag(dx);
        cls_next.mdy = mag(dy);
        cls_next.mt[LANE_LEFT]   = mag(tl);
        cls_next.mt[LANE_RIGHT]  = mag(tr);
        cls_next.mt[LANE_TOP]    = mag(tt);
        cls_next.mt[LANE_BOTTOM] = mag(tb);
    end

    assign in_ready = !cls_valid_reg || !q_full;
    assign load     = in_valid && in_ready;
    assign push     = cls_valid_reg && !q_full;

    always_comb
    begin
        cls_valid_next = cls_valid_reg;
        if (load)
            cls_valid_next = 1'b1;
        else if (push)
            cls_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cls_valid_reg <= 1'b0;
        else
            cls_valid_reg <= cls_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cls_reg <= cls_next;
    end

    // products go straight into the queue storage
    always_comb
    begin
        job.visible = cls_reg.visible;
        job.x1      = cls_reg.x1;
        job.y1      = cls_reg.y1;
        job.x2      = cls_reg.x2;
        job.y2      = cls_reg.y2;
        job.hit     = cls_reg.hit;
        job.neg     = cls_reg.neg;
        job.y1_lt   = cls_reg.y1_lt;
        job.y1_gt   = cls_reg.y1_gt;
        job.mdx     = cls_reg.mdx;
        job.mdy     = cls_reg.mdy;
        job.prod[LANE_LEFT]   = PW'(cls_reg.mdy) * PW'(cls_reg.mt[LANE_LEFT]);
        job.prod[LANE_RIGHT]  = PW'(cls_reg.mdy) * PW'(cls_reg.mt[LANE_RIGHT]);
        job.prod[LANE_TOP]    = PW'(cls_reg.mdx) * PW'(cls_reg.mt[LANE_TOP]);
        job.prod[LANE_BOTTOM] = PW'(cls_reg.mdx) * PW'(cls_reg.mt[LANE_BOTTOM]);
    end

endmodule

// ===== src/lsrc_queue.sv =====
// ----------------------------------------------------------------------------
// lsrc_queue
// Short FIFO between the classify front and the divide back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsrc_queue
    import lsrc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wdata,
    output logic full,
    input  logic pop,
    output job_t rdata,
    output logic empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    `LSRC_NEVER(a_q_over, clk, rst_n, count_reg > CNT_W'(DEPTH), "queue count over depth")
    `LSRC_ASSERT(a_q_ptr, clk, rst_n, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "empty queue with split pointers")

endmodule

// ===== src/lsrc_back.sv =====
// ----------------------------------------------------------------------------
// lsrc_back
// Pipelined restoring dividers for the crossing on each window edge, edge
// select and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsrc_back
    import lsrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  win_t win,
    input  job_t job,
    input  logic q_empty,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int NS = DW;  // one quotient bit per stage

    stg_t        st_reg [NS+1];
    stg_t        st_next [NS];
    stg_t        st_in;
    logic [NS:0] v_reg;
    logic        advance;
    logic        out_valid_reg;
    out_t        out_reg;
    out_t        out_next;

    assign advance   = !out_valid_reg || out_ready;
    assign pop       = advance && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // dividend upper half seeds the remainder; it is below the divisor
    // whenever the crossing is one that can be used
    always_comb
    begin
        st_in.visible = job.visible;
        st_in.x1      = job.x1;
        st_in.y1      = job.y1;
        st_in.x2      = job.x2;
        st_in.y2      = job.y2;
        st_in.hit     = job.hit;
        st_in.neg     = job.neg;
        st_in.y1_lt   = job.y1_lt;
        st_in.y1_gt   = job.y1_gt;
        st_in.mdx     = job.mdx;
        st_in.mdy     = job.mdy;
        for (int l = 0; l < 4; l++)
        begin
            st_in.rem[l] = job.prod[l][PW-1:DW];
            st_in.low[l] = job.prod[l][DW-1:0];
            st_in.quo[l] = '0;
        end
    end

    always_comb
    begin
        logic [DW:0]   stp;
        logic [DW-1:0] dvs;
        for (int k = 0; k < NS; k++)
        begin
            st_next[k] = st_reg[k];
            for (int l = 0; l < 4; l++)
            begin
                dvs = (l < LANE_TOP) ? st_reg[k].mdx : st_reg[k].mdy;
                stp = div_step(st_reg[k].rem[l], st_reg[k].low[l][DW-1], dvs);
                st_next[k].rem[l] = stp[DW-1:0];
                st_next[k].low[l] = {st_reg[k].low[l][DW-2:0], 1'b0};
                st_next[k].quo[l] = {st_reg[k].quo[l][DW-2:0], stp[DW]};
            end
        end
    end

    // crossing, window check and edge priority
    always_comb
    begin
        logic signed [CR-1:0] base;
        logic signed [CR-1:0] qs;
        logic signed [CR-1:0] c [4];
        logic [3:0]           ok;
        logic                 done;
        stg_t                 s;
        s = st_reg[NS];
        for (int l = 0; l < 4; l++)
        begin
            base = (l < LANE_TOP) ? CR'(s.y1) : CR'(s.x1);
            qs   = CR'(s.quo[l]);
            c[l] = s.neg[l] ? base - qs : base + qs;
        end
        for (int l = 0; l < 4; l++)
        begin
            if (l < LANE_TOP)
                ok[l] = s.hit[l] && c[l] >= CR'(win.top) && c[l] < CR'(win.bottom);
            else
                ok[l] = s.hit[l] && c[l] >= CR'(win.left) && c[l] < CR'(win.right);
        end
        out_next.visible = s.visible;
        out_next.left_x  = s.x1;
        out_next.left_y  = s.y1;
        out_next.right_x = s.x2;
        out_next.right_y = s.y2;
        done = !s.visible;
        if (!done && ok[LANE_LEFT])
        begin
            out_next.left_x = win.left;
            out_next.left_y = c[LANE_LEFT][CW-1:0];
            done = 1'b1;
        end
        if (!done && ok[LANE_RIGHT])
        begin
            out_next.right_x = win.right;
            out_next.right_y = c[LANE_RIGHT][CW-1:0];
            done = 1'b1;
        end
        if (!done && ok[LANE_TOP])
        begin
            // the endpoint above the window moves
            if (s.y1_lt)
            begin
                out_next.left_x = c[LANE_TOP][CW-1:0];
                out_next.left_y = win.top;
            end
            else
            begin
                out_next.right_x = c[LANE_TOP][CW-1:0];
                out_next.right_y = win.top;
            end
            done = 1'b1;
        end
        if (!done && ok[LANE_BOTTOM])
        begin
            // the endpoint below the window moves
            if (s.y1_gt)
            begin
                out_next.left_x = c[LANE_BOTTOM][CW-1:0];
                out_next.left_y = win.bottom;
            end
            else
            begin
                out_next.right_x = c[LANE_BOTTOM][CW-1:0];
                out_next.right_y = win.bottom;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg         <= {v_reg[NS-1:0], !q_empty};
            out_valid_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0] <= st_in;
            for (int k = 0; k < NS; k++)
                st_reg[k+1] <= st_next[k];
            out_reg <= out_next;
        end
    end

    `LSRC_ASSERT(a_bk_load, clk, rst_n, pop |=> v_reg[0], "popped job not in first divide stage")
    `LSRC_ASSERT(a_bk_hold, clk, rst_n, (!advance && v_reg[NS]) |=> v_reg[NS], "stalled job lost in divider")

endmodule

// ===== src/line_segment_rect_clip.sv =====
// ----------------------------------------------------------------------------
// line_segment_rect_clip
// Clips one Q12.4 segment against a half-open rectangular window.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data   : one segment per transfer (in_t).
//   out_valid/out_ready/out_data: one result per segment, in order (out_t).
//   cfg_valid/cfg_ready/cfg_index/cfg_data: window register writes; index 0
//     left, 1 right, 2 top, 3 bottom. cfg_ready is always high. Write only
//     while no segment is in flight.
//   Throughput: one segment per cycle while the receiver takes results. Path
//     from the input transfer to out_valid: classify stage, products written
//     into the queue, divider entry register, one stage per quotient bit of
//     the four parallel restoring dividers (17), edge-select output register.
//   Reset: window returns to left 0, right 10240, top 0, bottom 7680 (a
//     640 x 480 pixel window); all pipeline and queue state is emptied.
//   Receiver stall: the divider pipeline and output register hold; the
//     queue fills, and then in_ready drops once the classify stage is full.
// ----------------------------------------------------------------------------
module line_segment_rect_clip
    import lsrc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  in_t           in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output out_t          out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [CW-1:0] cfg_data
);

    win_t win_reg;
    win_t win_next;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    job_t job_wr;
    job_t job_rd;

    assign cfg_ready = 1'b1;

    // window registers, written one at a time
    always_comb
    begin
        win_next = win_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LEFT:   win_next.left   = cfg_data;
                REG_RIGHT:  win_next.right  = cfg_data;
                REG_TOP:    win_next.top    = cfg_data;
                REG_BOTTOM: win_next.bottom = cfg_data;
                default:    win_next = win_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.left   <= RST_LEFT;
            win_reg.right  <= RST_RIGHT;
            win_reg.top    <= RST_TOP;
            win_reg.bottom <= RST_BOTTOM;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    // front: order, classify, multiply
    lsrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .win      (win_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .push     (push),
        .job      (job_wr),
        .q_full   (q_full)
    );

    // decouples the two halves so each can stall on its own
    lsrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_wr),
        .full  (q_full),
        .pop   (pop),
        .rdata (job_rd),
        .empty (q_empty)
    );

    // back: divide, pick the first usable edge, hold the result
    lsrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (win_reg),
        .job       (job_rd),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== sim/clip_checker.sv =====
// ----------------------------------------------------------------------------
// clip_checker
// Watches the segment, result and window channels of the clipper, predicts
// each clipped segment and compares it with the block's output in order.
// ----------------------------------------------------------------------------
module clip_checker
    import lsrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  in_t           in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  out_t          out_data,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [CW-1:0] cfg_data,
    output int            fail_count,
    output int            pending,
    output int            seen_visible,
    output int            seen_hidden
);

    out_t clip_expected_q[$];
    longint win_l, win_r, win_tp, win_b;

    // base + trunc(num*t/den); SV '/' truncates toward zero
    function automatic longint edge_cross(longint base, longint num, longint t,
                                          longint den);
        return base + (num * t) / den;
    endfunction

    function automatic out_t clip_segment(in_t seg);
        longint x1, y1, x2, y2, tmp, ylo, yhi, c;
        logic vis;
        logic done;
        out_t r;
        x1 = seg.start_x; y1 = seg.start_y;
        x2 = seg.end_x;   y2 = seg.end_y;
        vis = 1'b1;
        done = 1'b0;
        if (x1 > x2)
        begin
            tmp = x1; x1 = x2; x2 = tmp;
            tmp = y1; y1 = y2; y2 = tmp;
        end
        ylo = (y1 < y2) ? y1 : y2;
        yhi = (y1 < y2) ? y2 : y1;
        if (!(x1 >= win_l && x1 < win_r && y1 >= win_tp && y1 < win_b) &&
            !(x2 >= win_l && x2 < win_r && y2 >= win_tp && y2 < win_b))
            vis = 1'b0;
        else if (x1 == x2 && y1 == y2)
            vis = 1'b0;
        else
        begin
            if (x1 < win_l && win_l < x2)
            begin
                c = edge_cross(y1, y2 - y1, win_l - x1, x2 - x1);
                if (c >= win_tp && c < win_b)
                begin
                    x1 = win_l; y1 = c; done = 1'b1;
                end
            end
            if (!done && x1 < win_r && win_r < x2)
            begin
                c = edge_cross(y1, y2 - y1, win_r - x1, x2 - x1);
                if (c >= win_tp && c < win_b)
                begin
                    x2 = win_r; y2 = c; done = 1'b1;
                end
            end
            if (!done && ylo < win_tp && win_tp < yhi)
            begin
                c = edge_cross(x1, x2 - x1, win_tp - y1, y2 - y1);
                if (c >= win_l && c < win_r)
                begin
                    if (y1 < y2)
                    begin
                        x1 = c; y1 = win_tp;
                    end
                    else
                    begin
                        x2 = c; y2 = win_tp;
                    end
                    done = 1'b1;
                end
            end
            if (!done && ylo < win_b && win_b < yhi)
            begin
                c = edge_cross(x1, x2 - x1, win_b - y1, y2 - y1);
                if (c >= win_l && c < win_r)
                begin
                    if (y1 > y2)
                    begin
                        x1 = c; y1 = win_b;
                    end
                    else
                    begin
                        x2 = c; y2 = win_b;
                    end
                end
            end
        end
        r.visible = vis;
        r.left_x  = x1[CW-1:0];
        r.left_y  = y1[CW-1:0];
        r.right_x = x2[CW-1:0];
        r.right_y = y2[CW-1:0];
        return r;
    endfunction

    assign pending = clip_expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_t exp_r;
        if (!rst_n)
        begin
            win_l = RST_LEFT;
            win_r = RST_RIGHT;
            win_tp = RST_TOP;
            win_b = RST_BOTTOM;
            clip_expected_q.delete();
            fail_count <= 0;
            seen_visible <= 0;
            seen_hidden <= 0;
        end
        else
        begin
            // output compared first: a fresh input can't land on the same edge
            if (out_valid && out_ready)
            begin
                if (clip_expected_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result %h", out_data);
                end
                else
                begin
                    exp_r = clip_expected_q.pop_front();
                    if (exp_r.visible) seen_visible <= seen_visible + 1;
                    else seen_hidden <= seen_hidden + 1;
                    if (exp_r.visible !== out_data.visible ||
                        exp_r.left_x !== out_data.left_x ||
                        exp_r.left_y !== out_data.left_y ||
                        exp_r.right_x !== out_data.right_x ||
                        exp_r.right_y !== out_data.right_y)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: exp vis=%b l=(%0d,%0d) r=(%0d,%0d) got vis=%b l=(%0d,%0d) r=(%0d,%0d)",
                                exp_r.visible, exp_r.left_x, exp_r.left_y,
                                exp_r.right_x, exp_r.right_y, out_data.visible,
                                out_data.left_x, out_data.left_y,
                                out_data.right_x, out_data.right_y);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LEFT:   win_l = $signed(cfg_data);
                    REG_RIGHT:  win_r = $signed(cfg_data);
                    REG_TOP:    win_tp = $signed(cfg_data);
                    REG_BOTTOM: win_b = $signed(cfg_data);
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                clip_expected_q.push_back(clip_segment(in_data));
        end
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives segments and window writes into the clipper with random gaps and
// output stalls; the checker predicts and compares every clipped result.
// ----------------------------------------------------------------------------
module tb;
    import lsrc_pkg::*;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    in_t           in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    out_t          out_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = REG_LEFT;
    logic [CW-1:0] cfg_data = '0;
    int            fail_count, pending, seen_visible, seen_hidden;
    logic          stim_done = 1'b0;

    always #5 clk = ~clk;

    line_segment_rect_clip dut (.*);

    clip_checker chk (.*);

    // one window register write per transfer
    task automatic write_window(logic [1:0] idx, logic [CW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(int l, int r, int t, int b);
        write_window(REG_LEFT, CW'(l));
        write_window(REG_RIGHT, CW'(r));
        write_window(REG_TOP, CW'(t));
        write_window(REG_BOTTOM, CW'(b));
    endtask

    // drain in-flight segments before touching the window
    task automatic wait_idle();
        while (pending != 0) @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    // segment transfer; valid stays high across back-to-back items
    task automatic send_segment(int sx, int sy, int ex, int ey, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= '{CW'(sx), CW'(sy), CW'(ex), CW'(ey)};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // coordinate mostly near the window, sometimes anywhere
    function automatic int pick_coord(int lo, int hi);
        if ($urandom_range(0, 7) == 0)
            return $signed(16'($urandom));
        return $urandom_range(0, hi - lo + 400) + lo - 200;
    endfunction

    // receiver: random stalls, with stretches of none
    initial
    begin
        int w;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0) w = 0;
            else w = $urandom_range(0, 15);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    initial
    begin
        int wl, wr, wt, wb;
        int gap;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset window 0..10240 x 0..7680
        send_segment(100, 100, 5000, 3000, 0);        // fully inside
        send_segment(-500, 1000, 2000, 2000, 0);      // left edge
        send_segment(9000, 500, 12000, 1500, 0);      // right edge
        send_segment(2000, -800, 3000, 600, 0);       // top, start replaced
        send_segment(3000, 600, 2000, -800, 0);       // top, end replaced
        send_segment(4000, 7000, 4500, 9000, 0);      // bottom edge
        send_segment(4500, 9000, 4000, 7000, 0);      // bottom, other order
        send_segment(-100, -100, -200, -50, 0);       // both outside
        send_segment(300, 300, 300, 300, 0);          // coincident
        send_segment(500, 100, 500, 200, 0);          // equal x
        send_segment(0, 0, 10239, 7679, 0);           // inclusive corners
        send_segment(10240, 100, 100, 100, 0);        // on exclusive edge
        send_segment(-32768, -32768, 32767, 32767, 0);
        send_segment(32767, -32768, 100, 100, 0);
        send_segment(-32768, 32767, 100, 7000, 0);
        send_segment(-600, -600, 200, 300, 0);        // corner, top misses
        end_burst();
        wait_idle();

        // extreme and inverted windows
        set_window(-32768, 32767, -32768, 32767);
        send_segment(-32768, -32768, 32766, 32766, 0);
        send_segment(32767, 32767, -32768, 0, 0);
        send_segment(-1, 1, 1, -1, 0);
        end_burst();
        wait_idle();
        set_window(1000, -1000, 500, 400);
        send_segment(0, 0, 100, 100, 0);
        send_segment(-2000, 450, 2000, 450, 0);
        end_burst();
        wait_idle();

        // random phases, each with a fresh window
        for (int ph = 0; ph < 8; ph++)
        begin
            wl = $signed(16'($urandom_range(0, 8000) - 4000));
            wr = wl + $urandom_range(16, 12000);
            wt = $signed(16'($urandom_range(0, 8000) - 4000));
            wb = wt + $urandom_range(16, 12000);
            if (wr > 32767) wr = 32767;
            if (wb > 32767) wb = 32767;
            set_window(wl, wr, wt, wb);
            for (int i = 0; i < 50; i++)
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
                send_segment(pick_coord(wl, wr), pick_coord(wt, wb),
                             pick_coord(wl, wr), pick_coord(wt, wb), gap);
            end
            end_burst();
            wait_idle();
        end

        stim_done <= 1'b1;
    end

    // final verdict
    initial
    begin
        wait (stim_done);
        repeat (40) @(posedge clk);
        $display("covered %0d visible and %0d rejected segments over 11 windows",
                 seen_visible, seen_hidden);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== line_segment_rect_clip.f =====
+incdir+src
src/lsrc_pkg.sv
src/lsrc_front.sv
src/lsrc_queue.sv
src/lsrc_back.sv
src/line_segment_rect_clip.sv
sim/clip_checker.sv
sim/tb.sv
